// ===== rtl/core/two_body_scattering_kinematics_defines.svh =====
// Assertion macros for the two-body scattering kinematics block.
// Included by the top level; expects clk and arst_n in scope.
`ifndef TWO_BODY_SCATTERING_KINEMATICS_DEFINES_SVH
`define TWO_BODY_SCATTERING_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
`define TBSK_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbsk assertion failed");
`define TBSK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbsk assertion failed");
`else
`define TBSK_ASSERT(label, ante, cons)
`define TBSK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/tbsk_pkg.sv =====
// Shared types and constants of the two-body scattering kinematics block.
// No dependencies; used by every module of the block.
package tbsk_pkg;

	localparam int VAL_W    = 32;
	localparam int T_W      = 40;
	localparam int A_W      = 67;
	localparam int EDIV_QW  = 32;
	localparam int EDIV_DW  = 33;
	localparam int CDIV_QW  = 33;
	localparam int CDIV_DW  = 33;
	localparam int SQRT_QW  = 32;
	localparam int E_LANES  = 4;
	localparam int P_LANES  = 2;

	localparam logic [1:0] REG_MASS_IN_A  = 2'd0;
	localparam logic [1:0] REG_MASS_IN_B  = 2'd1;
	localparam logic [1:0] REG_MASS_OUT_A = 2'd2;
	localparam logic [1:0] REG_MASS_OUT_B = 2'd3;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_BELOW = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [VAL_W-1:0]        cm_energy;
		logic signed [T_W-1:0]   t_mandelstam;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0]          energy_in_a;
		logic [VAL_W-1:0]          energy_in_b;
		logic [VAL_W-1:0]          momentum_in;
		logic [VAL_W-1:0]          energy_out_a;
		logic [VAL_W-1:0]          energy_out_b;
		logic signed [VAL_W-1:0]   momentum_out_x;
		logic signed [VAL_W-1:0]   momentum_out_z;
		status_t                   status;
	} out_t;

	typedef struct packed {
		logic                    below;
		logic signed [T_W-1:0]   t;
	} ediv_side_t;

	typedef struct packed {
		logic [VAL_W-1:0]        e1;
		logic [VAL_W-1:0]        e2;
		logic [VAL_W-1:0]        e3;
		logic [VAL_W-1:0]        e4;
		logic                    below;
		logic signed [T_W-1:0]   t;
	} psq_side_t;

	typedef struct packed {
		logic [VAL_W-1:0]   e1;
		logic [VAL_W-1:0]   e2;
		logic [VAL_W-1:0]   e3;
		logic [VAL_W-1:0]   e4;
		logic [VAL_W-1:0]   p1;
		logic [VAL_W-1:0]   p3;
		status_t            status;
	} cdiv_side_t;

	typedef struct packed {
		logic [VAL_W-1:0]          e1;
		logic [VAL_W-1:0]          e2;
		logic [VAL_W-1:0]          e3;
		logic [VAL_W-1:0]          e4;
		logic [VAL_W-1:0]          p1;
		logic signed [VAL_W+1:0]   pz;
		status_t                   status;
	} xsq_side_t;

endpackage

// ===== rtl/core/two_body_scattering_kinematics.sv =====
// Top level of the two-body scattering kinematics block.
// Depends on tbsk_pkg, tbsk_div, tbsk_sqrt and the block's defines header.
// One word is taken per clock while the skid register is empty, and the results appear in
// order. The pipeline holds four bit-per-stage chains in series: the 32-stage divider for
// the four particle energies, the 32-stage square root for the two momenta, the 33-stage
// divider for the cosine term and the 32-stage square root for the transverse momentum,
// with ten more stages of multipliers and adders around them. A result that is not taken
// holds in the output register and one more word parks in a skid register; the input then
// stalls until the output moves. Write the masses only while the block holds no word.
`include "two_body_scattering_kinematics_defines.svh"

module two_body_scattering_kinematics (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  tbsk_pkg::in_t    item,
	output logic             result_valid,
	input  logic             result_ready,
	output tbsk_pkg::out_t   result,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_wdata
);

	logic [31:0] mass_in_a_q, mass_in_b_q, mass_out_a_q, mass_out_b_q;
	logic        en;
	logic        skid_v_q;
	logic        result_valid_q;
	tbsk_pkg::out_t result_q, skid_q;

	assign en         = !skid_v_q;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_in_a_q  <= '0;
			mass_in_b_q  <= '0;
			mass_out_a_q <= '0;
			mass_out_b_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tbsk_pkg::REG_MASS_IN_A:  mass_in_a_q  <= cfg_wdata;
				tbsk_pkg::REG_MASS_IN_B:  mass_in_b_q  <= cfg_wdata;
				tbsk_pkg::REG_MASS_OUT_A: mass_out_a_q <= cfg_wdata;
				tbsk_pkg::REG_MASS_OUT_B: mass_out_b_q <= cfg_wdata;
			endcase
		end
	end

	// s1: threshold check and squares
	logic [32:0] sum_in_c, sum_out_c;
	logic        below_c;
	logic        v_s1, below_s1;
	logic [31:0] e_s1;
	logic signed [39:0] t_s1;
	logic [63:0] ee_s1;
	logic [3:0][63:0] msq_s1;

	assign sum_in_c  = {1'b0, mass_in_a_q} + {1'b0, mass_in_b_q};
	assign sum_out_c = {1'b0, mass_out_a_q} + {1'b0, mass_out_b_q};
	assign below_c   = (item.cm_energy == '0) || ({1'b0, item.cm_energy} < sum_in_c) ||
		({1'b0, item.cm_energy} < sum_out_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			below_s1  <= below_c;
			e_s1      <= item.cm_energy;
			t_s1      <= item.t_mandelstam;
			ee_s1     <= 64'(item.cm_energy) * 64'(item.cm_energy);
			msq_s1[0] <= 64'(mass_in_a_q) * 64'(mass_in_a_q);
			msq_s1[1] <= 64'(mass_in_b_q) * 64'(mass_in_b_q);
			msq_s1[2] <= 64'(mass_out_a_q) * 64'(mass_out_a_q);
			msq_s1[3] <= 64'(mass_out_b_q) * 64'(mass_out_b_q);
		end
	end

	// s2: numerators of the energy split
	logic [65:0] n0_c, n1_c, n2_c, n3_c;
	logic        v_s2;
	logic [3:0][64:0] num_s2;
	logic [32:0] den_s2;
	tbsk_pkg::ediv_side_t eside_s2;

	assign n0_c = {2'b00, ee_s1} + {2'b00, msq_s1[0]} - {2'b00, msq_s1[1]};
	assign n1_c = {2'b00, ee_s1} + {2'b00, msq_s1[1]} - {2'b00, msq_s1[0]};
	assign n2_c = {2'b00, ee_s1} + {2'b00, msq_s1[2]} - {2'b00, msq_s1[3]};
	assign n3_c = {2'b00, ee_s1} + {2'b00, msq_s1[3]} - {2'b00, msq_s1[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2[0]      <= n0_c[64:0];
			num_s2[1]      <= n1_c[64:0];
			num_s2[2]      <= n2_c[64:0];
			num_s2[3]      <= n3_c[64:0];
			den_s2         <= {e_s1, 1'b0};
			eside_s2.below <= below_s1;
			eside_s2.t     <= t_s1;
		end
	end

	logic ediv_v;
	logic [3:0][31:0] ediv_q;
	tbsk_pkg::ediv_side_t ediv_side;

	tbsk_div #(
		.LANES (tbsk_pkg::E_LANES),
		.QW    (tbsk_pkg::EDIV_QW),
		.DW    (tbsk_pkg::EDIV_DW),
		.SW    ($bits(tbsk_pkg::ediv_side_t))
	) u_ediv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       ({4{den_s2}}),
		.side      (eside_s2),
		.out_valid (ediv_v),
		.quot      (ediv_q),
		.side_out  (ediv_side)
	);

	// s3: squares for the momenta
	logic        v_s3;
	logic [63:0] e1sq_s3, e3sq_s3, m1sq_s3, m3sq_s3;
	tbsk_pkg::psq_side_t pside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= ediv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1sq_s3        <= 64'(ediv_q[0]) * 64'(ediv_q[0]);
			e3sq_s3        <= 64'(ediv_q[2]) * 64'(ediv_q[2]);
			m1sq_s3        <= 64'(mass_in_a_q) * 64'(mass_in_a_q);
			m3sq_s3        <= 64'(mass_out_a_q) * 64'(mass_out_a_q);
			pside_s3.e1    <= ediv_q[0];
			pside_s3.e2    <= ediv_q[1];
			pside_s3.e3    <= ediv_q[2];
			pside_s3.e4    <= ediv_q[3];
			pside_s3.below <= ediv_side.below;
			pside_s3.t     <= ediv_side.t;
		end
	end

	// s4: radicands, zero where the energy does not exceed the mass
	logic        v_s4;
	logic [1:0][63:0] rad_s4;
	tbsk_pkg::psq_side_t pside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4[0] <= (pside_s3.e1 > mass_in_a_q) ? (e1sq_s3 - m1sq_s3) : '0;
			rad_s4[1] <= (pside_s3.e3 > mass_out_a_q) ? (e3sq_s3 - m3sq_s3) : '0;
			pside_s4  <= pside_s3;
		end
	end

	logic psq_v;
	logic [1:0][31:0] psq_root;
	tbsk_pkg::psq_side_t psq_side;

	tbsk_sqrt #(
		.LANES (tbsk_pkg::P_LANES),
		.QW    (tbsk_pkg::SQRT_QW),
		.SW    ($bits(tbsk_pkg::psq_side_t))
	) u_psqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rad       (rad_s4),
		.side      (pside_s4),
		.out_valid (psq_v),
		.root      (psq_root),
		.side_out  (psq_side)
	);

	// s5: products for t0 and the physical range
	logic [31:0] d2_c, pp_c;
	logic        v_s5, below_s5;
	logic [63:0] dsq_s5, psq_s5, pq_s5;
	logic signed [39:0] t_s5;
	logic [31:0] e1_s5, e2_s5, e3_s5, e4_s5, p1_s5, p3_s5;

	assign d2_c = (psq_side.e1 >= psq_side.e3) ? (psq_side.e1 - psq_side.e3) :
		(psq_side.e3 - psq_side.e1);
	assign pp_c = (psq_root[0] >= psq_root[1]) ? (psq_root[0] - psq_root[1]) :
		(psq_root[1] - psq_root[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= psq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s5   <= 64'(d2_c) * 64'(d2_c);
			psq_s5   <= 64'(pp_c) * 64'(pp_c);
			pq_s5    <= 64'(psq_root[0]) * 64'(psq_root[1]);
			below_s5 <= psq_side.below;
			t_s5     <= psq_side.t;
			e1_s5    <= psq_side.e1;
			e2_s5    <= psq_side.e2;
			e3_s5    <= psq_side.e3;
			e4_s5    <= psq_side.e4;
			p1_s5    <= psq_root[0];
			p3_s5    <= psq_root[1];
		end
	end

	// s6: a = t0 - t, range check, status
	logic [66:0] a_c, dd_c, dmarg_c;
	logic        bad_c;
	tbsk_pkg::status_t status_c;
	logic        v_s6;
	logic [66:0] a_s6;
	tbsk_pkg::cdiv_side_t cside_s6;

	assign a_c     = {3'b000, dsq_s5} - {3'b000, psq_s5} - {{11{t_s5[39]}}, t_s5, 16'h0000};
	assign dd_c    = {1'b0, pq_s5, 2'b00};
	assign dmarg_c = dd_c - a_c;
	assign bad_c   = a_c[66] || dmarg_c[66];
	assign status_c = below_s5 ? tbsk_pkg::STATUS_BELOW :
		(bad_c ? tbsk_pkg::STATUS_RANGE : tbsk_pkg::STATUS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6            <= a_c;
			cside_s6.e1     <= e1_s5;
			cside_s6.e2     <= e2_s5;
			cside_s6.e3     <= e3_s5;
			cside_s6.e4     <= e4_s5;
			cside_s6.p1     <= p1_s5;
			cside_s6.p3     <= p3_s5;
			cside_s6.status <= status_c;
		end
	end

	logic cdiv_v;
	logic [0:0][32:0] cdiv_q;
	tbsk_pkg::cdiv_side_t cdiv_side;

	tbsk_div #(
		.LANES (1),
		.QW    (tbsk_pkg::CDIV_QW),
		.DW    (tbsk_pkg::CDIV_DW),
		.SW    ($bits(tbsk_pkg::cdiv_side_t))
	) u_cdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (a_s6[65:0]),
		.den       ({cside_s6.p1, 1'b0}),
		.side      (cside_s6),
		.out_valid (cdiv_v),
		.quot      (cdiv_q),
		.side_out  (cdiv_side)
	);

	// s7: pz = p3 - c, clamp c to 2 p3, drop it when p1 is zero
	logic [32:0] p3x2_c, cc_c;
	logic [33:0] pz_c, pzn_c;
	logic        v_s7;
	logic [33:0] pz_s7;
	logic [31:0] az_s7;
	tbsk_pkg::cdiv_side_t cside_s7;

	assign p3x2_c = {cdiv_side.p3, 1'b0};
	assign cc_c   = (cdiv_side.p1 == '0) ? '0 :
		((cdiv_q[0] > p3x2_c) ? p3x2_c : cdiv_q[0]);
	assign pz_c   = {2'b00, cdiv_side.p3} - {1'b0, cc_c};
	assign pzn_c  = -pz_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= cdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s7    <= pz_c;
			az_s7    <= pz_c[33] ? pzn_c[31:0] : pz_c[31:0];
			cside_s7 <= cdiv_side;
		end
	end

	// s8, s9: p3^2 - pz^2
	logic        v_s8, v_s9;
	logic [63:0] p3sq_s8, azsq_s8, radx_s9;
	tbsk_pkg::xsq_side_t xside_s8, xside_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p3sq_s8         <= 64'(cside_s7.p3) * 64'(cside_s7.p3);
			azsq_s8         <= 64'(az_s7) * 64'(az_s7);
			xside_s8.e1     <= cside_s7.e1;
			xside_s8.e2     <= cside_s7.e2;
			xside_s8.e3     <= cside_s7.e3;
			xside_s8.e4     <= cside_s7.e4;
			xside_s8.p1     <= cside_s7.p1;
			xside_s8.pz     <= pz_s7;
			xside_s8.status <= cside_s7.status;
			radx_s9         <= p3sq_s8 - azsq_s8;
			xside_s9        <= xside_s8;
		end
	end

	logic xsq_v;
	logic [0:0][31:0] xsq_root;
	tbsk_pkg::xsq_side_t xsq_side;

	tbsk_sqrt #(
		.LANES (1),
		.QW    (tbsk_pkg::SQRT_QW),
		.SW    ($bits(tbsk_pkg::xsq_side_t))
	) u_xsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.rad       (radx_s9),
		.side      (xside_s9),
		.out_valid (xsq_v),
		.root      (xsq_root),
		.side_out  (xsq_side)
	);

	// s10: saturate and zero the fields of a flagged word
	tbsk_pkg::out_t res_c;
	logic        v_s10;
	tbsk_pkg::out_t res_s10;

	always_comb begin
		res_c = '0;
		res_c.status = xsq_side.status;
		if (xsq_side.status == tbsk_pkg::STATUS_OK) begin
			res_c.energy_in_a  = xsq_side.e1;
			res_c.energy_in_b  = xsq_side.e2;
			res_c.momentum_in  = xsq_side.p1;
			res_c.energy_out_a = xsq_side.e3;
			res_c.energy_out_b = xsq_side.e4;
			res_c.momentum_out_x = xsq_root[0][31] ? 32'h7fff_ffff : xsq_root[0];
			if (!xsq_side.pz[33] && (xsq_side.pz[32:31] != 2'b00)) begin
				res_c.momentum_out_z = 32'h7fff_ffff;
			end else if (xsq_side.pz[33] && (xsq_side.pz[32:31] != 2'b11)) begin
				res_c.momentum_out_z = 32'h8000_0000;
			end else begin
				res_c.momentum_out_z = xsq_side.pz[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= xsq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= res_c;
		end
	end

	// output register with skid
	logic take;
	logic out_free;

	assign take     = en && v_s10;
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_v_q       <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				result_valid_q <= 1'b1;
				skid_v_q       <= 1'b0;
			end else begin
				result_valid_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				result_q <= skid_q;
			end else if (take) begin
				result_q <= res_s10;
			end
		end else if (take) begin
			skid_q <= res_s10;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TBSK_ASSERT(a_skid_implies_out, skid_v_q, result_valid)
	`TBSK_ASSERT_NEXT(a_skid_holds, skid_v_q && !result_ready, skid_v_q)
	`TBSK_ASSERT(a_flag_zeroes, result_valid && (result.status != tbsk_pkg::STATUS_OK), (result.energy_in_a == '0) && (result.momentum_in == '0) && (result.momentum_out_z == '0))
	`TBSK_ASSERT(a_px_nonneg, result_valid, !result.momentum_out_x[31])

endmodule

// ===== rtl/core/tbsk_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on tbsk_pkg for default widths. Requires num >> QW below den.
module tbsk_div #(
	parameter int LANES = 1,
	parameter int QW    = tbsk_pkg::EDIV_QW,
	parameter int DW    = tbsk_pkg::EDIV_DW,
	parameter int SW    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][DW+QW-1:0]   num,
	input  logic [LANES-1:0][DW-1:0]      den,
	input  logic [SW-1:0]                 side,
	output logic                          out_valid,
	output logic [LANES-1:0][QW-1:0]      quot,
	output logic [SW-1:0]                 side_out
);

	logic                       v_s    [QW];
	logic [LANES-1:0][QW-1:0]   w_s    [QW];
	logic [SW-1:0]              side_s [QW];
	logic [LANES-1:0][DW-1:0]   rem_s  [QW-1];
	logic [LANES-1:0][DW-1:0]   den_s  [QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                       v_in;
		logic [LANES-1:0][DW-1:0]   rem_in;
		logic [LANES-1:0][DW-1:0]   den_in;
		logic [LANES-1:0][QW-1:0]   w_in;
		logic [SW-1:0]              side_in;
		logic [LANES-1:0][DW-1:0]   rem_nx;
		logic [LANES-1:0][QW-1:0]   w_nx;

		if (k == 0) begin : g_head
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = num[l][DW+QW-1:QW];
					w_in[l]   = num[l][QW-1:0];
				end
			end
			assign v_in    = in_valid;
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_body
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign w_in    = w_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			logic [DW:0] part;
			logic [DW:0] diff;
			for (int l = 0; l < LANES; l++) begin
				part = {rem_in[l], w_in[l][QW-1]};
				diff = part - {1'b0, den_in[l]};
				if (part >= {1'b0, den_in[l]}) begin
					rem_nx[l] = diff[DW-1:0];
					w_nx[l]   = {w_in[l][QW-2:0], 1'b1};
				end else begin
					rem_nx[l] = part[DW-1:0];
					w_nx[l]   = {w_in[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[k]    <= w_nx;
				side_s[k] <= side_in;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= rem_nx;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quot      = w_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

// ===== rtl/core/tbsk_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, several lanes.
// Depends on tbsk_pkg for default widths. Gives floor(sqrt(rad)).
module tbsk_sqrt #(
	parameter int LANES = 1,
	parameter int QW    = tbsk_pkg::SQRT_QW,
	parameter int SW    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][2*QW-1:0]    rad,
	input  logic [SW-1:0]                 side,
	output logic                          out_valid,
	output logic [LANES-1:0][QW-1:0]      root,
	output logic [SW-1:0]                 side_out
);

	logic                         v_s    [QW];
	logic [LANES-1:0][QW-1:0]     root_s [QW];
	logic [SW-1:0]                side_s [QW];
	logic [LANES-1:0][QW+1:0]     rem_s  [QW-1];
	logic [LANES-1:0][2*QW-1:0]   rad_s  [QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                         v_in;
		logic [LANES-1:0][QW+1:0]     rem_in;
		logic [LANES-1:0][QW-1:0]     root_in;
		logic [LANES-1:0][2*QW-1:0]   rad_in;
		logic [SW-1:0]                side_in;
		logic [LANES-1:0][QW+1:0]     rem_nx;
		logic [LANES-1:0][QW-1:0]     root_nx;
		logic [LANES-1:0][2*QW-1:0]   rad_nx;

		if (k == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_in = side;
		end else begin : g_body
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			logic [QW+3:0] part;
			logic [QW+3:0] trial;
			logic [QW+3:0] diff;
			for (int l = 0; l < LANES; l++) begin
				part  = {rem_in[l], rad_in[l][2*QW-1:2*QW-2]};
				trial = {2'b00, root_in[l], 2'b01};
				diff  = part - trial;
				rad_nx[l] = {rad_in[l][2*QW-3:0], 2'b00};
				if (part >= trial) begin
					rem_nx[l]  = diff[QW+1:0];
					root_nx[l] = {root_in[l][QW-2:0], 1'b1};
				end else begin
					rem_nx[l]  = part[QW+1:0];
					root_nx[l] = {root_in[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= root_nx;
				side_s[k] <= side_in;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= rem_nx;
					rad_s[k] <= rad_nx;
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign root      = root_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule
